[src/radix_integer_literal_parser_defines.svh]
// Assertion macros for the radix integer literal parser.
// Included by the top level; no other dependencies.
`ifndef RADIX_INTEGER_LITERAL_PARSER_DEFINES_SVH
`define RADIX_INTEGER_LITERAL_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RILP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rilp assertion failed");

// antecedent implies consequent in the next cycle
`define RILP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rilp assertion failed");

`endif

[src/rilp_pkg.sv]
// Shared types and character constants for the radix integer literal parser.
// No dependencies.
package rilp_pkg;

   localparam int unsigned RESULT_BITS = 64;

   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_F  = 8'h46;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_B  = 8'h62;
   localparam logic [7:0] CHAR_LC_D  = 8'h64;
   localparam logic [7:0] CHAR_LC_E  = 8'h65;
   localparam logic [7:0] CHAR_LC_F  = 8'h66;
   localparam logic [7:0] CHAR_LC_O  = 8'h6F;
   localparam logic [7:0] CHAR_LC_X  = 8'h78;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam logic [4:0] RADIX_2  = 5'd2;
   localparam logic [4:0] RADIX_8  = 5'd8;
   localparam logic [4:0] RADIX_10 = 5'd10;
   localparam logic [4:0] RADIX_16 = 5'd16;

   // character class of one input byte
   typedef struct packed {
      logic       is_hash;
      logic       is_sign;
      logic       is_minus;
      logic       is_digit;     // hex digit of any case
      logic [3:0] digit;
      logic       prefix_ok;    // valid letter after '#'
      logic       prefix_set;   // letter changes the radix ('e' does not)
      logic [4:0] prefix_radix;
   } char_class_type;

   typedef struct packed {
      logic fire;
      logic last;
   } step_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] value;
      logic                   ok;
      logic                   ovf;
   } result_type;

endpackage

[src/rilp_decode.sv]
// Character classifier: digit value, sign, '#' and prefix letters.
// Depends on rilp_pkg.
module rilp_decode (
   input  logic [7:0]              char_code,
   output rilp_pkg::char_class_type cls
);

   logic [7:0] lower;

   assign lower = char_code | rilp_pkg::CASE_BIT;

   always_comb begin
      cls              = '0;
      cls.is_hash      = (char_code == rilp_pkg::CHAR_HASH);
      cls.is_sign      = (char_code == rilp_pkg::CHAR_PLUS) ||
                         (char_code == rilp_pkg::CHAR_MINUS);
      cls.is_minus     = (char_code == rilp_pkg::CHAR_MINUS);
      cls.prefix_radix = rilp_pkg::RADIX_10;

      if (char_code >= rilp_pkg::CHAR_ZERO && char_code <= rilp_pkg::CHAR_NINE) begin
         cls.is_digit = 1'b1;
         cls.digit    = 4'(char_code - rilp_pkg::CHAR_ZERO);
      end else if (char_code >= rilp_pkg::CHAR_LC_A && char_code <= rilp_pkg::CHAR_LC_F) begin
         cls.is_digit = 1'b1;
         cls.digit    = 4'(char_code - rilp_pkg::CHAR_LC_A + 8'd10);
      end else if (char_code >= rilp_pkg::CHAR_UC_A && char_code <= rilp_pkg::CHAR_UC_F) begin
         cls.is_digit = 1'b1;
         cls.digit    = 4'(char_code - rilp_pkg::CHAR_UC_A + 8'd10);
      end

      // only letters fold onto the lowercase codes below
      unique case (lower)
         rilp_pkg::CHAR_LC_E: begin
            cls.prefix_ok = 1'b1;
         end
         rilp_pkg::CHAR_LC_B: begin
            cls.prefix_ok    = 1'b1;
            cls.prefix_set   = 1'b1;
            cls.prefix_radix = rilp_pkg::RADIX_2;
         end
         rilp_pkg::CHAR_LC_O: begin
            cls.prefix_ok    = 1'b1;
            cls.prefix_set   = 1'b1;
            cls.prefix_radix = rilp_pkg::RADIX_8;
         end
         rilp_pkg::CHAR_LC_D: begin
            cls.prefix_ok    = 1'b1;
            cls.prefix_set   = 1'b1;
            cls.prefix_radix = rilp_pkg::RADIX_10;
         end
         rilp_pkg::CHAR_LC_X: begin
            cls.prefix_ok    = 1'b1;
            cls.prefix_set   = 1'b1;
            cls.prefix_radix = rilp_pkg::RADIX_16;
         end
         default: begin
            cls.prefix_ok = 1'b0;
         end
      endcase
   end

endmodule

[src/rilp_core.sv]
// Parse state, accumulator and overflow tracking; builds the result on the
// last character. Depends on rilp_pkg.
module rilp_core #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rilp_pkg::step_type       step,
   input  rilp_pkg::char_class_type cls,
   output rilp_pkg::result_type     result
);

   localparam int unsigned WIDE = VALUE_BITS + 5;

   typedef enum logic [3:0] {
      PH_PREFIX = 4'b0001,
      PH_HASH   = 4'b0010,
      PH_SIGNED = 4'b0100,
      PH_DIGITS = 4'b1000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [4:0]            radix_ff, radix_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  err_ff, err_in;
   logic                  ovf_ff, ovf_in;

   logic [WIDE-1:0]       acc_wide;
   logic [WIDE-1:0]       scaled;
   logic [WIDE-1:0]       limit;
   logic                  digit_ok;
   logic [VALUE_BITS-1:0] signed_val;

   assign acc_wide = WIDE'(acc_ff);
   assign digit_ok = cls.is_digit && (5'(cls.digit) < radix_ff);

   // exact acc * radix + digit; radix is one of four fixed values
   always_comb begin
      case (radix_ff)
         rilp_pkg::RADIX_2:  scaled = acc_wide << 1;
         rilp_pkg::RADIX_8:  scaled = acc_wide << 3;
         rilp_pkg::RADIX_16: scaled = acc_wide << 4;
         default:            scaled = (acc_wide << 3) + (acc_wide << 1);
      endcase
      scaled = scaled + WIDE'(cls.digit);
   end

   // magnitude limit: 2^(N-1) for negative, 2^(N-1)-1 otherwise
   assign limit = (WIDE'(1) << (VALUE_BITS - 1)) - WIDE'(!neg_ff);

   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      ovf_in   = ovf_ff;
      if (!err_ff) begin
         if (phase_ff == PH_HASH) begin
            if (cls.prefix_ok) begin
               phase_in = PH_PREFIX;
               if (cls.prefix_set) begin
                  radix_in = cls.prefix_radix;
               end
            end else begin
               err_in = 1'b1;
            end
         end else if (phase_ff == PH_PREFIX && cls.is_hash) begin
            phase_in = PH_HASH;
         end else if (phase_ff == PH_PREFIX && cls.is_sign) begin
            phase_in = PH_SIGNED;
            neg_in   = cls.is_minus;
         end else if (digit_ok) begin
            phase_in = PH_DIGITS;
            acc_in   = scaled[VALUE_BITS-1:0];
            if (scaled > limit) begin
               ovf_in = 1'b1;
            end
         end else begin
            err_in = 1'b1;
         end
      end
   end

   assign signed_val = neg_in ? (VALUE_BITS'(0) - acc_in) : acc_in;

   always_comb begin
      result.ok    = !err_in && (phase_in == PH_DIGITS);
      result.ovf   = result.ok && ovf_in;
      result.value = result.ok ? rilp_pkg::RESULT_BITS'($signed(signed_val)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         radix_ff <= rilp_pkg::RADIX_10;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         err_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (step.fire) begin
         if (step.last) begin
            phase_ff <= PH_PREFIX;
            radix_ff <= rilp_pkg::RADIX_10;
            neg_ff   <= 1'b0;
            acc_ff   <= '0;
            err_ff   <= 1'b0;
            ovf_ff   <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            radix_ff <= radix_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            err_ff   <= err_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

endmodule

[src/radix_integer_literal_parser.sv]
// Top level of the radix integer literal parser: input register, character
// classifier, parse core and result register.
// Depends on rilp_pkg, rilp_decode, rilp_core and the defines header.
//
// Usage:
//   Characters of a literal arrive one per beat on the req_ channel, low
//   byte of req_tdata, with req_tlast on the final character. Prefixes
//   #b #o #d #x #e, an optional sign, then digits of the current radix.
//   One result beat per literal leaves on the rsp_ channel: rsp_tdata is
//   the 64-bit signed value, rsp_tuser[0] says the literal was well formed
//   and rsp_tuser[1] flags overflow of VALUE_BITS bits.
//   A last character passes the input register, and its result is then
//   held in the result register. Throughput is one character per cycle
//   unless a last character waits on the result slot; the loop that sets
//   it is the accumulator update (shift-and-add by radix, limit compare).
//   Synchronous reset empties both registers and returns the parser to the
//   start of a literal. While the receiver stalls, the result stays in its
//   register and characters that produce no result keep flowing; a last
//   character waits in the input register until the result slot frees.
`include "radix_integer_literal_parser_defines.svh"

module radix_integer_literal_parser #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] parsed_value
   output logic [1:0]  rsp_tuser    // [0] parse_ok, [1] overflowed
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_last_ff, in_last_in;
   logic       advance;

   logic                 out_valid_ff, out_valid_in;
   rilp_pkg::result_type out_ff, out_in;

   rilp_pkg::char_class_type cls;
   rilp_pkg::step_type       step;
   rilp_pkg::result_type     result;

   // only a last character needs the result slot
   assign advance    = !in_last_ff || !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step.fire  = in_valid_ff && advance;
   assign step.last  = in_last_ff;

   rilp_decode u_decode (
      .char_code (in_char_ff),
      .cls       (cls)
   );

   rilp_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cls    (cls),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (step.fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step.fire && step.last) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_ff.value;
   assign rsp_tuser[0] = out_ff.ok;
   assign rsp_tuser[1] = out_ff.ovf;

   `RILP_ASSERT_SAME(a_bad_is_zero, clock, reset, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata == 64'd0 && !rsp_tuser[1])
   `RILP_ASSERT_SAME(a_result_from_last, clock, reset, $rose(rsp_tvalid),
      $past(in_valid_ff && in_last_ff))
   `RILP_ASSERT_NEXT(a_drain_empties, clock, reset,
      rsp_tvalid && rsp_tready && !(step.fire && step.last), !rsp_tvalid)

endmodule
